FILE: design/frontier_gain_distance_argmax_top_macros.svh
// assertion helpers for the checker file
`ifndef FRONTIER_GAIN_DISTANCE_ARGMAX_TOP_MACROS_SVH
`define FRONTIER_GAIN_DISTANCE_ARGMAX_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FGDA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FGDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fgda_pkg.sv
package fgda_pkg;

    // default field widths
    localparam int COORD_WIDTH_DEF = 24;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int ID_WIDTH_DEF    = 16;

    // slice width of the cross-product multipliers
    localparam int CHUNK_WIDTH = 32;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROBOT_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROBOT_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROBOT_Z = 2'd2;

    // queue entry: ids, count, count squared, distance squared, last flag
    function automatic int entry_width(input int cw, input int nw, input int iw);
        return 2 * iw + 3 * nw + 2 * cw + 3;
    endfunction

endpackage

FILE: design/fgda_front.sv
module fgda_front
    import fgda_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 in_valid,
    output logic                                                 in_stall,
    input  logic [ID_WIDTH-1:0]                                  submap_id,
    input  logic [ID_WIDTH-1:0]                                  frontier_idx,
    input  logic signed [COORD_WIDTH-1:0]                        centroid_x,
    input  logic signed [COORD_WIDTH-1:0]                        centroid_y,
    input  logic signed [COORD_WIDTH-1:0]                        centroid_z,
    input  logic [COUNT_WIDTH-1:0]                               point_count,
    input  logic                                                 last_item,
    input  logic signed [COORD_WIDTH-1:0]                        robot_x,
    input  logic signed [COORD_WIDTH-1:0]                        robot_y,
    input  logic signed [COORD_WIDTH-1:0]                        robot_z,
    input  logic                                                 q_full,
    output logic                                                 q_push,
    output logic [entry_width(COORD_WIDTH, COUNT_WIDTH, ID_WIDTH)-1:0] q_data
);

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int DW    = 2 * COORD_WIDTH + 2;
    localparam int CSQ_W = 2 * COUNT_WIDTH;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIFF = 2'd1;
    localparam logic [1:0] F_SQ   = 2'd2;
    localparam logic [1:0] F_SUM  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic                          accept;

    logic [ID_WIDTH-1:0]           sub_reg;
    logic [ID_WIDTH-1:0]           frt_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg;
    logic signed [COORD_WIDTH-1:0] cy_reg;
    logic signed [COORD_WIDTH-1:0] cz_reg;
    logic [COUNT_WIDTH-1:0]        cnt_reg;
    logic                          last_reg;
    logic [COORD_WIDTH-1:0]        dx_reg;
    logic [COORD_WIDTH-1:0]        dy_reg;
    logic [COORD_WIDTH-1:0]        dz_reg;
    logic [SQ_W-1:0]               sqx_reg;
    logic [SQ_W-1:0]               sqy_reg;
    logic [SQ_W-1:0]               sqz_reg;
    logic [CSQ_W-1:0]              csq_reg;
    logic [DW-1:0]                 d2_sum;

    // magnitude of a signed difference, one bit wider before the fold
    function automatic logic [COORD_WIDTH-1:0] abs_diff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic [COORD_WIDTH:0] d;
        logic [COORD_WIDTH:0] n;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        n = -d;
        return d[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
    endfunction

    // handshake: take a record when idle, or while the previous one leaves
    assign in_stall = !((state_reg == F_IDLE) || ((state_reg == F_SUM) && !q_full));
    assign accept   = in_valid && !in_stall;
    assign q_push   = (state_reg == F_SUM) && !q_full;

    // squared distance of the record
    assign d2_sum = DW'(sqx_reg) + DW'(sqy_reg) + DW'(sqz_reg);
    assign q_data = {sub_reg, frt_reg, cnt_reg, csq_reg, d2_sum, last_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_DIFF;
            F_DIFF:  state_next = F_SQ;
            F_SQ:    state_next = F_SUM;
            F_SUM:
            begin
                if (!q_full)
                begin
                    state_next = accept ? F_DIFF : F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // record capture and arithmetic stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sub_reg  <= submap_id;
            frt_reg  <= frontier_idx;
            cx_reg   <= centroid_x;
            cy_reg   <= centroid_y;
            cz_reg   <= centroid_z;
            cnt_reg  <= point_count;
            last_reg <= last_item;
        end
        if (state_reg == F_DIFF)
        begin
            dx_reg <= abs_diff(cx_reg, robot_x);
            dy_reg <= abs_diff(cy_reg, robot_y);
            dz_reg <= abs_diff(cz_reg, robot_z);
        end
        if (state_reg == F_SQ)
        begin
            sqx_reg <= {{COORD_WIDTH{1'b0}}, dx_reg} * {{COORD_WIDTH{1'b0}}, dx_reg};
            sqy_reg <= {{COORD_WIDTH{1'b0}}, dy_reg} * {{COORD_WIDTH{1'b0}}, dy_reg};
            sqz_reg <= {{COORD_WIDTH{1'b0}}, dz_reg} * {{COORD_WIDTH{1'b0}}, dz_reg};
            csq_reg <= {{COUNT_WIDTH{1'b0}}, cnt_reg} * {{COUNT_WIDTH{1'b0}}, cnt_reg};
        end
    end

endmodule

FILE: design/fgda_queue.sv
module fgda_queue
    import fgda_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/fgda_back.sv
module fgda_back
    import fgda_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 q_empty,
    output logic                                                 q_pop,
    input  logic [entry_width(COORD_WIDTH, COUNT_WIDTH, ID_WIDTH)-1:0] q_data,
    output logic                                                 out_valid,
    input  logic                                                 out_stall,
    output logic                                                 found,
    output logic [ID_WIDTH-1:0]                                  best_submap,
    output logic [ID_WIDTH-1:0]                                  best_frontier,
    output logic [COUNT_WIDTH-1:0]                               gain
);

    localparam int DW    = 2 * COORD_WIDTH + 2;
    localparam int CSQ_W = 2 * COUNT_WIDTH;
    localparam int NCH   = (DW + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
    localparam int BW    = NCH * CHUNK_WIDTH;
    localparam int PW    = CSQ_W + BW;
    localparam int MW    = CSQ_W + CHUNK_WIDTH;
    localparam int KW    = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_CMP  = 2'd2;

    // queue entry fields
    logic [ID_WIDTH-1:0]    q_sub;
    logic [ID_WIDTH-1:0]    q_frt;
    logic [COUNT_WIDTH-1:0] q_cnt;
    logic [CSQ_W-1:0]       q_csq;
    logic [DW-1:0]          q_d2;
    logic                   q_last;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [KW-1:0]          k_reg;

    // record under test
    logic [ID_WIDTH-1:0]    e_sub_reg;
    logic [ID_WIDTH-1:0]    e_frt_reg;
    logic [COUNT_WIDTH-1:0] e_cnt_reg;
    logic [CSQ_W-1:0]       e_csq_reg;
    logic [DW-1:0]          e_d2_reg;
    logic                   e_last_reg;

    // cross-product datapath
    logic [BW-1:0]          bl_reg;
    logic [BW-1:0]          br_reg;
    logic [PW-1:0]          acc_l_reg;
    logic [PW-1:0]          acc_r_reg;
    logic [MW-1:0]          prod_l;
    logic [MW-1:0]          prod_r;

    // running best
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [CSQ_W-1:0]       best_csq_reg;
    logic [DW-1:0]          best_d2_reg;
    logic [ID_WIDTH-1:0]    best_sub_reg;
    logic [ID_WIDTH-1:0]    best_frt_reg;

    // result register
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [ID_WIDTH-1:0]    out_sub_reg;
    logic [ID_WIDTH-1:0]    out_frt_reg;
    logic [COUNT_WIDTH-1:0] gain_reg;

    logic                   win;
    logic                   out_free;
    logic                   go;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [ID_WIDTH-1:0]    w_sub;
    logic [ID_WIDTH-1:0]    w_frt;

    assign {q_sub, q_frt, q_cnt, q_csq, q_d2, q_last} = q_data;

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // one slice per cycle, most significant first
    assign prod_l = {{CHUNK_WIDTH{1'b0}}, e_csq_reg}
                  * {{CSQ_W{1'b0}}, bl_reg[BW-1 -: CHUNK_WIDTH]};
    assign prod_r = {{CHUNK_WIDTH{1'b0}}, best_csq_reg}
                  * {{CSQ_W{1'b0}}, br_reg[BW-1 -: CHUNK_WIDTH]};

    // strict win keeps the earlier record on ties
    assign win      = acc_l_reg > acc_r_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign go       = !e_last_reg || out_free;
    assign w_cnt    = win ? e_cnt_reg : best_cnt_reg;
    assign w_sub    = win ? e_sub_reg : best_sub_reg;
    assign w_frt    = win ? e_frt_reg : best_frt_reg;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign best_submap   = out_sub_reg;
    assign best_frontier = out_frt_reg;
    assign gain          = gain_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (q_pop) state_next = B_MUL;
            B_MUL:   if (k_reg == '0) state_next = B_CMP;
            B_CMP:   if (go) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // operand load and accumulate
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            e_sub_reg  <= q_sub;
            e_frt_reg  <= q_frt;
            e_cnt_reg  <= q_cnt;
            e_csq_reg  <= q_csq;
            e_d2_reg   <= q_d2;
            e_last_reg <= q_last;
            bl_reg     <= BW'(best_d2_reg);
            br_reg     <= BW'(q_d2);
            acc_l_reg  <= '0;
            acc_r_reg  <= '0;
            k_reg      <= KW'(NCH - 1);
        end
        else if (state_reg == B_MUL)
        begin
            acc_l_reg <= (acc_l_reg << CHUNK_WIDTH) + PW'(prod_l);
            acc_r_reg <= (acc_r_reg << CHUNK_WIDTH) + PW'(prod_r);
            bl_reg    <= bl_reg << CHUNK_WIDTH;
            br_reg    <= br_reg << CHUNK_WIDTH;
            k_reg     <= k_reg - 1'b1;
        end
    end

    // best record update and clear at the end of a pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_cnt_reg <= '0;
            best_csq_reg <= '0;
            best_d2_reg  <= DW'(1);
            best_sub_reg <= '0;
            best_frt_reg <= '0;
        end
        else if ((state_reg == B_CMP) && go)
        begin
            if (e_last_reg)
            begin
                best_cnt_reg <= '0;
                best_csq_reg <= '0;
                best_d2_reg  <= DW'(1);
                best_sub_reg <= '0;
                best_frt_reg <= '0;
            end
            else if (win)
            begin
                best_cnt_reg <= e_cnt_reg;
                best_csq_reg <= e_csq_reg;
                best_d2_reg  <= e_d2_reg;
                best_sub_reg <= e_sub_reg;
                best_frt_reg <= e_frt_reg;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == B_CMP) && e_last_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == B_CMP) && e_last_reg && out_free)
        begin
            found_reg   <= (w_cnt != '0);
            out_sub_reg <= w_sub;
            out_frt_reg <= w_frt;
            gain_reg    <= w_cnt;
        end
    end

endmodule

FILE: design/frontier_gain_distance_argmax_top.sv
// Frontier selection by gain over distance. Records stream in on the input channel; on
// the record flagged last_item one result (found, best ids, gain) comes out and the
// running best is cleared for the next pass. The front end takes a record, then computes
// coordinate differences, squares and their sum in states F_DIFF, F_SQ and F_SUM, and
// can take the next record in the cycle its entry enters the two-entry queue. The back
// end handles one record at a time: it loads it from the queue, forms the exact cross
// products count^2 * distance^2 one 32-bit slice at a time, then compares and updates;
// it pops the next record only when idle, and holds the last record of a pass while
// the previous result is stalled. The user must write the robot position registers
// through the configuration port only while no pass is in flight; the block itself
// does not enforce this. cfg_ready is always high.
module frontier_gain_distance_argmax_top
    import fgda_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ID_WIDTH-1:0]           submap_id,
    input  logic [ID_WIDTH-1:0]           frontier_idx,
    input  logic signed [COORD_WIDTH-1:0] centroid_x,
    input  logic signed [COORD_WIDTH-1:0] centroid_y,
    input  logic signed [COORD_WIDTH-1:0] centroid_z,
    input  logic [COUNT_WIDTH-1:0]        point_count,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [ID_WIDTH-1:0]           best_submap,
    output logic [ID_WIDTH-1:0]           best_frontier,
    output logic [COUNT_WIDTH-1:0]        gain
);

    localparam int EW = entry_width(COORD_WIDTH, COUNT_WIDTH, ID_WIDTH);

    logic signed [COORD_WIDTH-1:0] robot_x_reg;
    logic signed [COORD_WIDTH-1:0] robot_y_reg;
    logic signed [COORD_WIDTH-1:0] robot_z_reg;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [EW-1:0] q_wr_data;
    logic [EW-1:0] q_rd_data;

    assign cfg_ready = 1'b1;

    // robot position registers, writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg <= '0;
            robot_y_reg <= '0;
            robot_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROBOT_X: robot_x_reg <= cfg_data;
                REG_ROBOT_Y: robot_y_reg <= cfg_data;
                REG_ROBOT_Z: robot_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // distance front end
    fgda_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .submap_id    (submap_id),
        .frontier_idx (frontier_idx),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .centroid_z   (centroid_z),
        .point_count  (point_count),
        .last_item    (last_item),
        .robot_x      (robot_x_reg),
        .robot_y      (robot_y_reg),
        .robot_z      (robot_z_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    // decoupling queue
    fgda_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // compare and select back end
    fgda_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .best_submap   (best_submap),
        .best_frontier (best_frontier),
        .gain          (gain)
    );

endmodule

FILE: design/fgda_checker.sv
`include "frontier_gain_distance_argmax_top_macros.svh"

module fgda_checker
    import fgda_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          found,
    input logic [ID_WIDTH-1:0]           best_submap,
    input logic [ID_WIDTH-1:0]           best_frontier,
    input logic [COUNT_WIDTH-1:0]        gain
);

    // the front end stalls in the cycle after it takes a record
    `FGDA_ASSERT_NEXT(a_in_busy_after_transfer, in_valid && !in_stall, in_stall,
        "front end took two records back to back")

    // a held result keeps its payload
    `FGDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(found) && $stable(gain) && $stable(best_submap)
            && $stable(best_frontier),
        "stalled result changed")

    // found means a nonzero winning count
    `FGDA_ASSERT_IMPL(a_found_gain, out_valid, found == (gain != '0),
        "found disagrees with gain")

    // an empty selection reports zero ids
    `FGDA_ASSERT_IMPL(a_not_found_ids, out_valid && !found,
        best_submap == '0 && best_frontier == '0, "ids not cleared when nothing found")

endmodule

bind frontier_gain_distance_argmax_top fgda_checker #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ID_WIDTH    (ID_WIDTH)
) u_fgda_checker (.*);
